[sv/lcd4_pkg.sv]
`default_nettype none
package lcd4_pkg;

  // Operation codes carried by the kind field
  typedef enum logic [2:0] {
    KIND_INIT   = 3'd0,
    KIND_CLEAR  = 3'd1,
    KIND_CURSOR = 3'd2,
    KIND_DATA   = 3'd3,
    KIND_CMD    = 3'd4
  } kind_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_INIT_PAUSE = 3'd0,
    REG_PAUSE      = 3'd1,
    REG_STROBE     = 3'd2,
    REG_FUNC_SET   = 3'd3,
    REG_ENTRY_MODE = 3'd4,
    REG_DISP_ON    = 3'd5,
    REG_CLEAR      = 3'd6
  } reg_idx_t;

  // Where the nibble of a step comes from
  typedef enum logic [1:0] {
    NIB_CONST = 2'd0,
    NIB_HI    = 2'd1,
    NIB_LO    = 2'd2
  } nib_sel_t;

  // Which byte the nibble is taken from
  typedef enum logic [2:0] {
    BYTE_OPER  = 3'd0,
    BYTE_FUNC  = 3'd1,
    BYTE_ENTRY = 3'd2,
    BYTE_DISP  = 3'd3,
    BYTE_CLEAR = 3'd4
  } byte_sel_t;

  // Which hold time a step uses
  typedef enum logic [1:0] {
    HOLD_STROBE = 2'd0,
    HOLD_SP     = 2'd1,
    HOLD_INIT   = 2'd2
  } hold_sel_t;

  // One control word of the step program
  typedef struct packed {
    logic      en;
    nib_sel_t  nib_sel;
    logic [3:0] nib_const;
    byte_sel_t byte_sel;
    hold_sel_t hold_sel;
    logic      last;
  } cw_t;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] ENT_INIT  = 5'd0;
  localparam logic [PC_W-1:0] ENT_CLEAR = 5'd21;
  localparam logic [PC_W-1:0] ENT_BYTE  = 5'd25;
  localparam logic [PC_W-1:0] PC_MAX    = 5'd28;

  function automatic cw_t mk(input logic en, input nib_sel_t ns, input logic [3:0] nc,
                             input byte_sel_t bs, input hold_sel_t hs, input logic last);
    cw_t w;
    w.en        = en;
    w.nib_sel   = ns;
    w.nib_const = nc;
    w.byte_sel  = bs;
    w.hold_sel  = hs;
    w.last      = last;
    return w;
  endfunction

  // Step program: init from ENT_INIT, clear from ENT_CLEAR, one byte from ENT_BYTE
  function automatic cw_t rom(input logic [PC_W-1:0] pc);
    cw_t w;
    case (pc)
      5'd0:  w = mk(1'b0, NIB_CONST, 4'h0, BYTE_OPER,  HOLD_INIT,   1'b0);
      5'd1:  w = mk(1'b1, NIB_CONST, 4'h3, BYTE_OPER,  HOLD_STROBE, 1'b0);
      5'd2:  w = mk(1'b0, NIB_CONST, 4'h3, BYTE_OPER,  HOLD_SP,     1'b0);
      5'd3:  w = mk(1'b1, NIB_CONST, 4'h3, BYTE_OPER,  HOLD_STROBE, 1'b0);
      5'd4:  w = mk(1'b0, NIB_CONST, 4'h3, BYTE_OPER,  HOLD_SP,     1'b0);
      5'd5:  w = mk(1'b1, NIB_CONST, 4'h3, BYTE_OPER,  HOLD_STROBE, 1'b0);
      5'd6:  w = mk(1'b0, NIB_CONST, 4'h3, BYTE_OPER,  HOLD_SP,     1'b0);
      5'd7:  w = mk(1'b1, NIB_CONST, 4'h2, BYTE_OPER,  HOLD_STROBE, 1'b0);
      5'd8:  w = mk(1'b0, NIB_CONST, 4'h2, BYTE_OPER,  HOLD_SP,     1'b0);
      5'd9:  w = mk(1'b1, NIB_HI,    4'h0, BYTE_FUNC,  HOLD_STROBE, 1'b0);
      5'd10: w = mk(1'b0, NIB_HI,    4'h0, BYTE_FUNC,  HOLD_STROBE, 1'b0);
      5'd11: w = mk(1'b1, NIB_LO,    4'h0, BYTE_FUNC,  HOLD_STROBE, 1'b0);
      5'd12: w = mk(1'b0, NIB_LO,    4'h0, BYTE_FUNC,  HOLD_STROBE, 1'b0);
      5'd13: w = mk(1'b1, NIB_HI,    4'h0, BYTE_ENTRY, HOLD_STROBE, 1'b0);
      5'd14: w = mk(1'b0, NIB_HI,    4'h0, BYTE_ENTRY, HOLD_STROBE, 1'b0);
      5'd15: w = mk(1'b1, NIB_LO,    4'h0, BYTE_ENTRY, HOLD_STROBE, 1'b0);
      5'd16: w = mk(1'b0, NIB_LO,    4'h0, BYTE_ENTRY, HOLD_STROBE, 1'b0);
      5'd17: w = mk(1'b1, NIB_HI,    4'h0, BYTE_DISP,  HOLD_STROBE, 1'b0);
      5'd18: w = mk(1'b0, NIB_HI,    4'h0, BYTE_DISP,  HOLD_STROBE, 1'b0);
      5'd19: w = mk(1'b1, NIB_LO,    4'h0, BYTE_DISP,  HOLD_STROBE, 1'b0);
      5'd20: w = mk(1'b0, NIB_LO,    4'h0, BYTE_DISP,  HOLD_STROBE, 1'b0);
      5'd21: w = mk(1'b1, NIB_HI,    4'h0, BYTE_CLEAR, HOLD_STROBE, 1'b0);
      5'd22: w = mk(1'b0, NIB_HI,    4'h0, BYTE_CLEAR, HOLD_STROBE, 1'b0);
      5'd23: w = mk(1'b1, NIB_LO,    4'h0, BYTE_CLEAR, HOLD_STROBE, 1'b0);
      5'd24: w = mk(1'b0, NIB_LO,    4'h0, BYTE_CLEAR, HOLD_SP,     1'b1);
      5'd25: w = mk(1'b1, NIB_HI,    4'h0, BYTE_OPER,  HOLD_STROBE, 1'b0);
      5'd26: w = mk(1'b0, NIB_HI,    4'h0, BYTE_OPER,  HOLD_STROBE, 1'b0);
      5'd27: w = mk(1'b1, NIB_LO,    4'h0, BYTE_OPER,  HOLD_STROBE, 1'b0);
      5'd28: w = mk(1'b0, NIB_LO,    4'h0, BYTE_OPER,  HOLD_STROBE, 1'b1);
      default: w = mk(1'b0, NIB_CONST, 4'h0, BYTE_OPER, HOLD_STROBE, 1'b1);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

[sv/char_lcd_nibble_write_sequencer_unit.sv]
// Character LCD 4-bit write sequencer.
// Input channel (in_*): one item per operation: init, clear, set cursor,
// data byte or raw command. Unknown kinds are taken and produce nothing.
// Output channel (out_*): one item per pin phase (RS, E, D7..D4 and the
// number of ticks to hold them); out_last marks the final phase.
// Config channel (cfg_*): always ready; cfg_index picks the register,
// cfg_data carries the value (upper bits dropped for 8-bit registers).
// Timing: a step program in a small ROM emits one phase per cycle while
// the output register is free. The first phase is loaded into the output
// register once the item is taken and the register is free; a byte
// operation emits 4 phases, clear 4, init 25. The step counter and
// the single output register set this rate. A new item is taken as
// soon as the last phase is loaded, even while it waits at the output.
// A stalled receiver holds the output register and freezes the step
// counter; nothing is dropped.
// Reset (rst_n low, synchronous) empties the output, idles the sequencer
// and loads the default register values.
`default_nettype none
module char_lcd_nibble_write_sequencer_unit #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_kind,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic [7:0]  in_column,
  input  wire logic [7:0]  in_row,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_register_select,
  output logic             out_enable,
  output logic [3:0]       out_nibble,
  output logic [24:0]      out_hold_ticks,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } st_t;

  localparam logic [7:0] COL_LIM = 8'(COLUMNS);
  localparam logic [7:0] ROW_LIM = 8'(ROWS);

  st_t                          st_r, st_nxt;
  logic [lcd4_pkg::PC_W-1:0]    pc_r, pc_nxt;
  logic [7:0]                   oper_r, oper_nxt;
  logic                         rs_r, rs_nxt;
  logic [23:0]                  init_pause_r, pause_r, strobe_r;
  logic [7:0]                   func_r, entry_r, disp_r, clear_r;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_rs_r, out_en_r, out_last_r;
  logic [3:0]                   out_nib_r;
  logic [24:0]                  out_hold_r;
  lcd4_pkg::cw_t                cw;
  logic                         adv, in_acc;
  logic [7:0]                   col_c, row_c, cur_addr, src_byte;
  logic [3:0]                   nib_val;
  logic [24:0]                  hold_val;

  assign in_ready  = (st_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign cw        = lcd4_pkg::rom(pc_r);
  assign adv       = (st_r == ST_RUN) && (!out_valid_r || out_ready);

  // Clamp the cursor and build the set-address command
  always_comb begin
    col_c    = (in_column >= COL_LIM) ? 8'd0 : in_column;
    row_c    = (in_row >= ROW_LIM) ? 8'd0 : in_row;
    cur_addr = 8'h80 | (row_c << 6) | col_c;
  end

  // Dispatch an item to its program entry
  always_comb begin
    st_nxt   = st_r;
    pc_nxt   = pc_r;
    oper_nxt = oper_r;
    rs_nxt   = rs_r;
    if (in_acc) begin
      case (lcd4_pkg::kind_t'(in_kind))
        lcd4_pkg::KIND_INIT: begin
          st_nxt = ST_RUN;
          pc_nxt = lcd4_pkg::ENT_INIT;
          rs_nxt = 1'b0;
        end
        lcd4_pkg::KIND_CLEAR: begin
          st_nxt = ST_RUN;
          pc_nxt = lcd4_pkg::ENT_CLEAR;
          rs_nxt = 1'b0;
        end
        lcd4_pkg::KIND_CURSOR: begin
          st_nxt   = ST_RUN;
          pc_nxt   = lcd4_pkg::ENT_BYTE;
          rs_nxt   = 1'b0;
          oper_nxt = cur_addr;
        end
        lcd4_pkg::KIND_DATA: begin
          st_nxt   = ST_RUN;
          pc_nxt   = lcd4_pkg::ENT_BYTE;
          rs_nxt   = 1'b1;
          oper_nxt = in_byte_value;
        end
        lcd4_pkg::KIND_CMD: begin
          st_nxt   = ST_RUN;
          pc_nxt   = lcd4_pkg::ENT_BYTE;
          rs_nxt   = 1'b0;
          oper_nxt = in_byte_value;
        end
        default: st_nxt = ST_IDLE;
      endcase
    end else if (adv) begin
      // Advance the step counter; drop back to idle after the last step
      pc_nxt = pc_r + 1'b1;
      if (cw.last) begin
        st_nxt = ST_IDLE;
      end
    end
  end

  // Datapath driven by the control word
  always_comb begin
    case (cw.byte_sel)
      lcd4_pkg::BYTE_FUNC:  src_byte = func_r;
      lcd4_pkg::BYTE_ENTRY: src_byte = entry_r;
      lcd4_pkg::BYTE_DISP:  src_byte = disp_r;
      lcd4_pkg::BYTE_CLEAR: src_byte = clear_r;
      default:              src_byte = oper_r;
    endcase
    case (cw.nib_sel)
      lcd4_pkg::NIB_HI: nib_val = src_byte[7:4];
      lcd4_pkg::NIB_LO: nib_val = src_byte[3:0];
      default:          nib_val = cw.nib_const;
    endcase
    case (cw.hold_sel)
      lcd4_pkg::HOLD_SP:   hold_val = {1'b0, strobe_r} + {1'b0, pause_r};
      lcd4_pkg::HOLD_INIT: hold_val = {1'b0, init_pause_r};
      default:             hold_val = {1'b0, strobe_r};
    endcase
  end

  // Output valid: set on a step, clear when taken
  always_comb begin
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      pc_r         <= lcd4_pkg::ENT_INIT;
      out_valid_r  <= 1'b0;
      init_pause_r <= 24'd100000;
      pause_r      <= 24'd5000;
      strobe_r     <= 24'd50;
      func_r       <= 8'd40;
      entry_r      <= 8'd6;
      disp_r       <= 8'd12;
      clear_r      <= 8'd1;
    end else begin
      st_r        <= st_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (lcd4_pkg::reg_idx_t'(cfg_index))
          lcd4_pkg::REG_INIT_PAUSE: init_pause_r <= cfg_data;
          lcd4_pkg::REG_PAUSE:      pause_r      <= cfg_data;
          lcd4_pkg::REG_STROBE:     strobe_r     <= cfg_data;
          lcd4_pkg::REG_FUNC_SET:   func_r       <= cfg_data[7:0];
          lcd4_pkg::REG_ENTRY_MODE: entry_r      <= cfg_data[7:0];
          lcd4_pkg::REG_DISP_ON:    disp_r       <= cfg_data[7:0];
          lcd4_pkg::REG_CLEAR:      clear_r      <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    oper_r <= oper_nxt;
    rs_r   <= rs_nxt;
    if (adv) begin
      out_rs_r   <= rs_r;
      out_en_r   <= cw.en;
      out_nib_r  <= nib_val;
      out_hold_r <= hold_val;
      out_last_r <= cw.last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_register_select = out_rs_r;
  assign out_enable          = out_en_r;
  assign out_nibble          = out_nib_r;
  assign out_hold_ticks      = out_hold_r;
  assign out_last            = out_last_r;

  // The step counter never runs past the end of the program
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_RUN |-> pc_r <= lcd4_pkg::PC_MAX)
    else $error("step counter out of program");

  // An E-high phase is never the final phase
  a_last_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_en_r |-> !out_last_r)
    else $error("operation ends with E high");

  // Loading the last step returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    adv && cw.last |=> st_r == ST_IDLE)
    else $error("sequencer did not stop after last step");

  // An init item starts the program at its entry
  a_init_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_kind == lcd4_pkg::KIND_INIT |=>
      st_r == ST_RUN && pc_r == lcd4_pkg::ENT_INIT)
    else $error("init did not start at its entry");

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  localparam int COLUMNS = 16;
  localparam int ROWS = 2;
  localparam logic [2:0] KIND_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] KIND_LAST_CODE = 3'd7;
  localparam logic [25:0] HOLD_MAX = 26'h1FFFFFF;
  localparam logic [23:0] TICKS_MAX = 24'hFFFFFF;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_PHASES = 5;
  localparam int ITEMS_PER_PHASE = 52;

  // One pin phase as seen on the result channel
  typedef struct packed {
    logic        rs;
    logic        en;
    logic [3:0]  nib;
    logic [24:0] hold;
    logic        last;
  } pin_phase_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_kind;
  logic [7:0]  in_byte_value;
  logic [7:0]  in_column;
  logic [7:0]  in_row;
  logic        out_valid;
  logic        out_ready;
  logic        out_register_select;
  logic        out_enable;
  logic [3:0]  out_nibble;
  logic [24:0] out_hold_ticks;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;

  // Shadow copy of the register file
  logic [23:0] shadow_init_pause;
  logic [23:0] shadow_pause;
  logic [23:0] shadow_strobe;
  logic [7:0]  shadow_func_set;
  logic [7:0]  shadow_entry_mode;
  logic [7:0]  shadow_disp_on;
  logic [7:0]  shadow_clear;

  pin_phase_t phase_q[$];
  int error_count;
  int phase_count;
  int quiet_cycles;
  int stall_left;
  bit in_idle_on;
  bit out_idle_on;

  char_lcd_nibble_write_sequencer_unit #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_byte_value(in_byte_value),
    .in_column(in_column),
    .in_row(in_row),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_register_select(out_register_select),
    .out_enable(out_enable),
    .out_nibble(out_nibble),
    .out_hold_ticks(out_hold_ticks),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  task automatic report_error(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Hold of an E-low phase with a pause added, saturating
  function automatic logic [24:0] hold_sum(logic [23:0] a, logic [23:0] b);
    logic [25:0] s;
    s = {2'b00, a} + {2'b00, b};
    return (s > HOLD_MAX) ? HOLD_MAX[24:0] : s[24:0];
  endfunction

  task automatic add_phase(logic rs, logic en, logic [3:0] nib, logic [24:0] hold);
    pin_phase_t p;
    p.rs = rs;
    p.en = en;
    p.nib = nib;
    p.hold = hold;
    p.last = 1'b0;
    phase_q.push_back(p);
  endtask

  task automatic add_strobe(logic rs, logic [3:0] nib, logic [23:0] extra);
    add_phase(rs, 1'b1, nib, {1'b0, shadow_strobe});
    add_phase(rs, 1'b0, nib, hold_sum(shadow_strobe, extra));
  endtask

  // High nibble first
  task automatic add_byte(logic rs, logic [7:0] b, logic [23:0] extra);
    add_strobe(rs, b[7:4], 24'd0);
    add_strobe(rs, b[3:0], extra);
  endtask

  // Queue the pin phases that one accepted item should produce
  task automatic predict_phases(logic [2:0] kind, logic [7:0] bv, logic [7:0] col,
                                logic [7:0] row);
    int prior;
    pin_phase_t tail;
    logic [7:0] c;
    logic [7:0] r;
    prior = phase_q.size();
    case (kind)
      lcd4_pkg::KIND_INIT: begin
        add_phase(1'b0, 1'b0, 4'h0, {1'b0, shadow_init_pause});
        repeat (3) add_strobe(1'b0, 4'h3, shadow_pause);
        add_strobe(1'b0, 4'h2, shadow_pause);
        add_byte(1'b0, shadow_func_set, 24'd0);
        add_byte(1'b0, shadow_entry_mode, 24'd0);
        add_byte(1'b0, shadow_disp_on, 24'd0);
        add_byte(1'b0, shadow_clear, shadow_pause);
      end
      lcd4_pkg::KIND_CLEAR: add_byte(1'b0, shadow_clear, shadow_pause);
      lcd4_pkg::KIND_CURSOR: begin
        c = (col >= COLUMNS) ? 8'd0 : col;
        r = (row >= ROWS) ? 8'd0 : row;
        add_byte(1'b0, 8'h80 | (r << 6) | c, 24'd0);
      end
      lcd4_pkg::KIND_DATA: add_byte(1'b1, bv, 24'd0);
      lcd4_pkg::KIND_CMD: add_byte(1'b0, bv, 24'd0);
      default: ;
    endcase
    // Mark the closing phase of this operation
    if (phase_q.size() > prior) begin
      tail = phase_q.pop_back();
      tail.last = 1'b1;
      phase_q.push_back(tail);
    end
  endtask

  task automatic apply_setting(logic [2:0] idx, logic [23:0] value);
    case (idx)
      lcd4_pkg::REG_INIT_PAUSE: shadow_init_pause = value;
      lcd4_pkg::REG_PAUSE: shadow_pause = value;
      lcd4_pkg::REG_STROBE: shadow_strobe = value;
      lcd4_pkg::REG_FUNC_SET: shadow_func_set = value[7:0];
      lcd4_pkg::REG_ENTRY_MODE: shadow_entry_mode = value[7:0];
      lcd4_pkg::REG_DISP_ON: shadow_disp_on = value[7:0];
      lcd4_pkg::REG_CLEAR: shadow_clear = value[7:0];
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [24:0] got, logic [24:0] want);
    if (got !== want)
      report_error($sformatf("phase %0d %s: got %0h, want %0h", phase_count, name, got,
                             want));
  endtask

  // Watch all three channels: predict, track settings, compare, watchdog
  always @(posedge clk) begin
    pin_phase_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_setting(cfg_index, cfg_data);
      if (in_valid && in_ready) predict_phases(in_kind, in_byte_value, in_column, in_row);
      if (out_valid && out_ready) begin
        if (phase_q.size() == 0) begin
          report_error($sformatf("phase %0d arrived with nothing expected", phase_count));
        end else begin
          want = phase_q.pop_front();
          check_field("register_select", 25'(out_register_select), 25'(want.rs));
          check_field("enable", 25'(out_enable), 25'(want.en));
          check_field("nibble", 25'(out_nibble), 25'(want.nib));
          check_field("hold_ticks", out_hold_ticks, want.hold);
          check_field("last", 25'(out_last), 25'(want.last));
        end
        phase_count++;
      end
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (out_idle_on) stall_left <= idle_len();
    end
  end

  // Present one item and hold it until taken; valid stays up if no gap follows
  task automatic send_item(logic [2:0] kind, logic [7:0] bv, logic [7:0] col,
                           logic [7:0] row);
    int gap;
    gap = in_idle_on ? idle_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_byte_value <= bv;
    in_column <= col;
    in_row <= row;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait for every expected phase, then let the block settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (phase_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(lcd4_pkg::reg_idx_t idx, logic [23:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all_regs(logic [23:0] value);
    write_reg(lcd4_pkg::REG_INIT_PAUSE, value);
    write_reg(lcd4_pkg::REG_PAUSE, value);
    write_reg(lcd4_pkg::REG_STROBE, value);
    write_reg(lcd4_pkg::REG_FUNC_SET, value);
    write_reg(lcd4_pkg::REG_ENTRY_MODE, value);
    write_reg(lcd4_pkg::REG_DISP_ON, value);
    write_reg(lcd4_pkg::REG_CLEAR, value);
  endtask

  // Every operation at reset settings, cursor corners and clamps, unknown kinds
  task automatic test_default_operations();
    send_item(lcd4_pkg::KIND_INIT, 8'h00, 8'h00, 8'h00);
    send_item(lcd4_pkg::KIND_CLEAR, 8'hFF, 8'hFF, 8'hFF);
    send_item(lcd4_pkg::KIND_CURSOR, 8'h00, 8'd0, 8'd0);
    send_item(lcd4_pkg::KIND_CURSOR, 8'h00, 8'(COLUMNS - 1), 8'(ROWS - 1));
    send_item(lcd4_pkg::KIND_CURSOR, 8'h00, 8'(COLUMNS), 8'd0);
    send_item(lcd4_pkg::KIND_CURSOR, 8'h00, 8'd3, 8'(ROWS));
    send_item(lcd4_pkg::KIND_CURSOR, 8'h00, 8'hFF, 8'hFF);
    send_item(lcd4_pkg::KIND_CURSOR, 8'h00, 8'(COLUMNS - 1), 8'd0);
    send_item(lcd4_pkg::KIND_CURSOR, 8'h00, 8'd0, 8'd1);
    send_item(lcd4_pkg::KIND_DATA, 8'h00, 8'h00, 8'h00);
    send_item(lcd4_pkg::KIND_DATA, 8'hFF, 8'h00, 8'h00);
    send_item(lcd4_pkg::KIND_DATA, 8'hA5, 8'h00, 8'h00);
    send_item(lcd4_pkg::KIND_CMD, 8'h00, 8'h00, 8'h00);
    send_item(lcd4_pkg::KIND_CMD, 8'hFF, 8'h00, 8'h00);
    send_item(lcd4_pkg::KIND_CMD, 8'h5A, 8'h00, 8'h00);
    for (int k = KIND_FIRST_UNUSED; k <= KIND_LAST_CODE; k++)
      send_item(3'(k), 8'hFF, 8'hFF, 8'hFF);
    send_item(lcd4_pkg::KIND_DATA, 8'h3C, 8'h00, 8'h00);
    wait_drained();
  endtask

  // All registers at their top value, then all at zero
  task automatic test_register_extremes();
    write_all_regs(TICKS_MAX);
    send_item(lcd4_pkg::KIND_INIT, 8'h00, 8'h00, 8'h00);
    send_item(lcd4_pkg::KIND_CLEAR, 8'h00, 8'h00, 8'h00);
    send_item(lcd4_pkg::KIND_DATA, 8'hFF, 8'h00, 8'h00);
    send_item(lcd4_pkg::KIND_CURSOR, 8'h00, 8'(COLUMNS - 1), 8'(ROWS - 1));
    wait_drained();
    write_all_regs(24'd0);
    send_item(lcd4_pkg::KIND_INIT, 8'h00, 8'h00, 8'h00);
    send_item(lcd4_pkg::KIND_CLEAR, 8'h00, 8'h00, 8'h00);
    send_item(lcd4_pkg::KIND_CMD, 8'h00, 8'h00, 8'h00);
    wait_drained();
  endtask

  function automatic logic [23:0] pick_setting();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 24'd0;
    else if (r < 30) return TICKS_MAX;
    else if (r < 65) return 24'($urandom_range(0, 1000));
    else return 24'($urandom);
  endfunction

  task automatic send_random_item(output bit counted);
    logic [2:0] kind;
    logic [7:0] col;
    logic [7:0] row;
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) kind = lcd4_pkg::KIND_INIT;
    else if (r < 94) kind = 3'($urandom_range(lcd4_pkg::KIND_CLEAR, lcd4_pkg::KIND_CMD));
    else kind = 3'($urandom_range(KIND_FIRST_UNUSED, KIND_LAST_CODE));
    col = $urandom_range(0, 1) ? 8'($urandom_range(0, COLUMNS + 1)) : 8'($urandom);
    row = $urandom_range(0, 1) ? 8'($urandom_range(0, ROWS + 1)) : 8'($urandom);
    send_item(kind, 8'($urandom), col, row);
    counted = (kind <= lcd4_pkg::KIND_CMD);
  endtask

  // Random traffic in phases, each with fresh settings and an idling mix chosen per phase
  task automatic test_random_traffic();
    int done;
    bit counted;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_reg(lcd4_pkg::REG_INIT_PAUSE, pick_setting());
      write_reg(lcd4_pkg::REG_PAUSE, pick_setting());
      write_reg(lcd4_pkg::REG_STROBE, pick_setting());
      write_reg(lcd4_pkg::REG_FUNC_SET, pick_setting());
      write_reg(lcd4_pkg::REG_ENTRY_MODE, pick_setting());
      write_reg(lcd4_pkg::REG_DISP_ON, pick_setting());
      write_reg(lcd4_pkg::REG_CLEAR, pick_setting());
      in_idle_on = (ph == 1) || (ph >= 3);
      out_idle_on = (ph == 2) || (ph >= 3);
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        send_random_item(counted);
        if (counted) done++;
        // Hold off midway until the output side has caught up
        if (counted && done == ITEMS_PER_PHASE / 2) wait_drained();
      end
      wait_drained();
    end
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = lcd4_pkg::KIND_INIT;
    in_byte_value = 8'h00;
    in_column = 8'h00;
    in_row = 8'h00;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = lcd4_pkg::REG_INIT_PAUSE;
    cfg_data = 24'd0;
    error_count = 0;
    phase_count = 0;
    quiet_cycles = 0;
    stall_left = 0;
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    shadow_init_pause = 24'd100000;
    shadow_pause = 24'd5000;
    shadow_strobe = 24'd50;
    shadow_func_set = 8'd40;
    shadow_entry_mode = 8'd6;
    shadow_disp_on = 8'd12;
    shadow_clear = 8'd1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_operations();
    test_register_extremes();
    test_random_traffic();
    wait_drained();

    if (phase_q.size() != 0)
      report_error($sformatf("%0d expected phases never arrived", phase_q.size()));
    if (error_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

[char_lcd_nibble_write_sequencer_unit.f]
sv/lcd4_pkg.sv
sv/char_lcd_nibble_write_sequencer_unit.sv
tb/sv/testbench.sv
